// ----- rtl/core/ckb_pkg.sv -----
// Package for the color-key blitter with palette translation.
// Holds the field widths, the payload and configuration types and the register indexes.
// No dependencies.
`timescale 1ns / 1ps

package ckb_pkg;

    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 24;
    localparam int CNT_W      = 12;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int TBL_DEPTH  = 256;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);
    localparam int SCR_W      = 17;

    localparam logic [PIX_W-1:0] TRANSPARENT_KEY = 8'd255;
    localparam logic [SCR_W-1:0] MAX_SCREEN_DIM  = 17'd4096;
    localparam logic [DIM_W-1:0] PIC_DIM_MAX     = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_X        = 3'd0,
        CFG_DEST_Y        = 3'd1,
        CFG_PIC_WIDTH     = 3'd2,
        CFG_PIC_HEIGHT    = 3'd3,
        CFG_ROW_PITCH     = 3'd4,
        CFG_SCREEN_WIDTH  = 3'd5,
        CFG_SCREEN_HEIGHT = 3'd6,
        CFG_TRANSLATE_EN  = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_PIXEL = 1'b1
    } t_func;

    typedef struct packed {
        logic              func;
        logic [PIX_W-1:0]  pixel;
        logic [TBL_AW-1:0] table_index;
        logic [PIX_W-1:0]  table_value;
    } t_in_item;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [PIX_W-1:0]  write_color;
        logic              bounds_error;
        logic              last_pixel;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0] dest_x;
        logic [POS_W-1:0] dest_y;
        logic [DIM_W-1:0] pic_width;
        logic [DIM_W-1:0] pic_height;
        logic [DIM_W-1:0] row_pitch;
        logic [DIM_W-1:0] screen_width;
        logic [DIM_W-1:0] screen_height;
        logic             translate_enable;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              err;
        logic              last;
    } t_rast;

endpackage

// ----- rtl/core/ckb_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ckb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ckb_cfg.sv -----
// Configuration register file of the blitter.
// Depends on ckb_pkg.
`timescale 1ns / 1ps

module ckb_cfg
    import ckb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_DEST_X:        n_cfg.dest_x           = i_data[POS_W-1:0];
                CFG_DEST_Y:        n_cfg.dest_y           = i_data[POS_W-1:0];
                CFG_PIC_WIDTH:     n_cfg.pic_width        = i_data[DIM_W-1:0];
                CFG_PIC_HEIGHT:    n_cfg.pic_height       = i_data[DIM_W-1:0];
                CFG_ROW_PITCH:     n_cfg.row_pitch        = i_data[DIM_W-1:0];
                CFG_SCREEN_WIDTH:  n_cfg.screen_width     = i_data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: n_cfg.screen_height    = i_data[DIM_W-1:0];
                CFG_TRANSLATE_EN:  n_cfg.translate_enable = i_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_x           <= '0;
            r_cfg.dest_y           <= '0;
            r_cfg.pic_width        <= 13'd1;
            r_cfg.pic_height       <= 13'd1;
            r_cfg.row_pitch        <= 13'd320;
            r_cfg.screen_width     <= 13'd320;
            r_cfg.screen_height    <= 13'd200;
            r_cfg.translate_enable <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/ckb_raster.sv -----
// Raster walker: column and row counters, row base, bounds check and last-pixel flag.
// Depends on ckb_pkg.
`timescale 1ns / 1ps

module ckb_raster
    import ckb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_advance,
    output t_rast o_rast
);

    logic [CNT_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_row_base;
    logic [CNT_W-1:0]  n_col;
    logic [CNT_W-1:0]  n_row;
    logic [ADDR_W-1:0] n_row_base;

    logic [DIM_W-1:0]        w;
    logic [DIM_W-1:0]        h;
    logic [SCR_W-1:0]        scr_w;
    logic [SCR_W-1:0]        scr_h;
    logic [SCR_W-1:0]        span_x;
    logic [SCR_W-1:0]        span_y;
    logic [POS_W+DIM_W-1:0]  prod;
    logic [POS_W+DIM_W-1:0]  start_sum;
    logic [ADDR_W-1:0]       base;
    logic                    end_row;
    logic                    end_pic;

    function automatic logic [DIM_W-1:0] clamp_pic(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = {{(DIM_W-1){1'b0}}, 1'b1};
        end else if (v > PIC_DIM_MAX) begin
            res = PIC_DIM_MAX;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [SCR_W-1:0] clamp_scr(input logic [DIM_W-1:0] v);
        logic [SCR_W-1:0] ext;
        ext = {{(SCR_W-DIM_W){1'b0}}, v};
        return (ext > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : ext;
    endfunction

    always_comb begin
        w      = clamp_pic(i_cfg.pic_width);
        h      = clamp_pic(i_cfg.pic_height);
        scr_w  = clamp_scr(i_cfg.screen_width);
        scr_h  = clamp_scr(i_cfg.screen_height);
        span_x = SCR_W'(i_cfg.dest_x) + SCR_W'(w);
        span_y = SCR_W'(i_cfg.dest_y) + SCR_W'(h);

        prod      = (POS_W+DIM_W)'(i_cfg.dest_y) * (POS_W+DIM_W)'(i_cfg.row_pitch);
        start_sum = prod + (POS_W+DIM_W)'(i_cfg.dest_x);
        base      = ((r_col == '0) && (r_row == '0)) ? start_sum[ADDR_W-1:0] : r_row_base;

        end_row = {1'b0, r_col} >= (w - 13'd1);
        end_pic = end_row && ({1'b0, r_row} >= (h - 13'd1));

        o_rast.addr = base + ADDR_W'(r_col);
        o_rast.err  = (span_x > scr_w) || (span_y > scr_h);
        o_rast.last = end_pic;

        if (end_pic) begin
            n_col      = '0;
            n_row      = '0;
            n_row_base = '0;
        end else if (end_row) begin
            n_col      = '0;
            n_row      = r_row + CNT_W'(1);
            n_row_base = base + ADDR_W'(i_cfg.row_pitch);
        end else begin
            n_col      = r_col + CNT_W'(1);
            n_row      = r_row;
            n_row_base = base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_row_base <= '0;
        end else if (i_advance) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_row_base <= n_row_base;
        end
    end

endmodule

// ----- rtl/core/color_key_blit_with_palette_lut_top.sv -----
// Top level of the color-key blitter with palette translation table.
// Depends on ckb_pkg, ckb_cfg, ckb_raster and ckb_ram.
//
// Channel   Direction  Handshake           Payload
// in        sink       i_in_valid/o_in_stall   t_in_item
// out       source     o_out_valid/i_out_stall t_out_item
// cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled.
// Each transfer passes the registered table RAM read stage, then the result register.
// Synchronous active-low reset clears counters and valid flags; the table is not cleared.
// A stall on the output holds the result register, then the table stage, then the input.
`timescale 1ns / 1ps

module color_key_blit_with_palette_lut_top
    import ckb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg             cfg;
    t_rast            rast;
    logic [PIX_W-1:0] tbl_rdata;

    logic             in_xfer;
    logic             is_pixel;
    logic             out_free;
    logic             s1_move;
    logic             s1_free;

    logic             r_s1_vld;
    logic             r_s1_pix_item;
    logic [PIX_W-1:0] r_s1_pixel;
    t_rast            r_s1_rast;

    logic             r_out_vld;
    t_out_item        r_out;
    t_out_item        n_out;

    assign o_cfg_ready = 1'b1;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_move    = r_s1_vld && out_free;
    assign s1_free    = !r_s1_vld || s1_move;
    assign o_in_stall = !s1_free;
    assign in_xfer    = i_in_valid && s1_free;
    assign is_pixel   = (i_in_data.func == FUNC_PIXEL);

    ckb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ckb_raster u_raster (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (in_xfer && is_pixel),
        .o_rast    (rast)
    );

    ckb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (in_xfer && !is_pixel),
        .i_waddr (i_in_data.table_index),
        .i_wdata (i_in_data.table_value),
        .i_re    (in_xfer && is_pixel),
        .i_raddr (i_in_data.pixel[TBL_AW-1:0]),
        .o_rdata (tbl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_pix_item <= is_pixel;
            r_s1_pixel    <= i_in_data.pixel;
            r_s1_rast     <= rast;
        end
    end

    always_comb begin
        n_out = '0;
        if (r_s1_pix_item) begin
            n_out.bounds_error = r_s1_rast.err;
            n_out.last_pixel   = r_s1_rast.last;
            if (!r_s1_rast.err && (r_s1_pixel != TRANSPARENT_KEY)) begin
                n_out.write_valid   = 1'b1;
                n_out.write_address = r_s1_rast.addr;
                n_out.write_color   = cfg.translate_enable ? tbl_rdata : r_s1_pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/ckb_checker.sv -----
// Port-level checker for the blitter top level, attached by bind.
// Depends on ckb_pkg and color_key_blit_with_palette_lut_top.
`timescale 1ns / 1ps

module ckb_checker
    import ckb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input t_out_item             o_out_data,
    input logic                  i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.write_valid) |->
        ((o_out_data.write_address == '0) && (o_out_data.write_color == '0)))
        else $error("suppressed write carries address or color");

    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bounds_error) |-> !o_out_data.write_valid)
        else $error("write made despite bounds error");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind color_key_blit_with_palette_lut_top ckb_checker u_ckb_checker (.*);
